// ----- sv/dtpm_pkg.sv -----
// Shared types and codes for the DNA trie pattern matcher.
`default_nettype none

package dtpm_pkg;

	localparam int POS_W = 20;

	localparam logic [1:0] CMD_PATTERN = 2'd0;
	localparam logic [1:0] CMD_TEXT    = 2'd1;
	localparam logic [1:0] CMD_FLUSH   = 2'd2;
	localparam logic [1:0] CMD_CLEAR   = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] sym;
		logic       pend;
	} dtpm_item_t;

	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] pos;
		logic             is_match;
		logic             last;
	} dtpm_emit_t;

	typedef struct packed {
		logic leaf;
		logic no_child;
	} dtpm_step_t;

endpackage

`default_nettype wire

// ----- sv/dtpm_step.sv -----
// Shared trie step unit: child select, empty-child and leaf tests on one node row.
`default_nettype none

module dtpm_step import dtpm_pkg::*; #(
	parameter int NW = 10
) (
	input  wire logic [4*NW-1:0] row,
	input  wire logic [1:0]      sym,
	output logic [NW-1:0]        nx,
	output dtpm_step_t           flags
);

	assign nx             = row[sym*NW +: NW];
	assign flags.no_child = (nx == '0);
	assign flags.leaf     = (row == '0);

endmodule

`default_nettype wire

// ----- sv/dtpm_core.sv -----
// Sequencer, child table and text window of the DNA trie pattern matcher.
`default_nettype none

module dtpm_core import dtpm_pkg::*; #(
	parameter int TRIE_NODES      = 1024,
	parameter int MAX_PATTERN_LEN = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire dtpm_item_t in_item,
	input  wire logic       slot_free,
	output dtpm_emit_t      emit,
	output logic            table_full
);

	localparam int NW = $clog2(TRIE_NODES);
	localparam int RW = 4 * NW;
	localparam int WW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
	localparam int FW = $clog2(MAX_PATTERN_LEN + 1);
	localparam int SW = FW + 1;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_INS      = 3'd1;
	localparam logic [2:0] ST_INS_ZERO = 3'd2;
	localparam logic [2:0] ST_START    = 3'd3;
	localparam logic [2:0] ST_EVAL     = 3'd4;
	localparam logic [2:0] ST_POST     = 3'd5;
	localparam logic [2:0] ST_END      = 3'd6;

	function automatic logic [WW-1:0] wrap_inc(input logic [WW-1:0] v);
		logic [FW-1:0] t;
		t = FW'(v) + FW'(1);
		return (t == FW'(MAX_PATTERN_LEN)) ? '0 : t[WW-1:0];
	endfunction

	logic [2:0]       state_q, state_d;
	logic             flush_q, flush_d;
	logic             end_q, end_d;
	logic [1:0]       sym_q, sym_d;
	logic [NW-1:0]    node_count_q, node_count_d;
	logic [NW-1:0]    ins_node_q, ins_node_d;
	logic [FW-1:0]    ins_depth_q, ins_depth_d;
	logic             ins_skip_q, ins_skip_d;
	logic             root_valid_q, root_valid_d;
	logic [WW-1:0]    head_q, head_d;
	logic [FW-1:0]    fill_q, fill_d;
	logic [POS_W-1:0] next_start_q, next_start_d;
	logic             overflow_q, overflow_d;
	logic [NW-1:0]    walk_node_q, walk_node_d;
	logic [FW-1:0]    walk_k_q, walk_k_d;
	logic [WW-1:0]    rp_q, rp_d;
	logic             matched_q, matched_d;
	logic [NW-1:0]    new_node_q, new_node_d;

	// Child table: one row of four pointers per node.
	logic [RW-1:0] child_mem [TRIE_NODES];
	logic [RW-1:0] child_rdata_q;
	logic [NW-1:0] child_raddr;
	logic          child_we;
	logic [NW-1:0] child_waddr;
	logic [RW-1:0] child_wdata;

	logic [1:0]    win_mem [MAX_PATTERN_LEN];
	logic [1:0]    win_rdata_q;
	logic [WW-1:0] win_raddr;
	logic          win_we;
	logic [WW-1:0] win_waddr;

	always_ff @(posedge clk) begin
		if (child_we) begin
			child_mem[child_waddr] <= child_wdata;
		end
		child_rdata_q <= child_mem[child_raddr];
	end

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[win_waddr] <= sym_d;
		end
		win_rdata_q <= win_mem[win_raddr];
	end

	// The root row is not cleared in memory; it reads as empty until first written.
	logic [NW-1:0] cur_node;
	logic [RW-1:0] row;
	logic [1:0]    step_sym;
	logic [NW-1:0] nx;
	dtpm_step_t    sflags;

	assign cur_node = (state_q == ST_INS) ? ins_node_q : walk_node_q;
	assign row      = (cur_node == '0 && !root_valid_q) ? '0 : child_rdata_q;
	assign step_sym = (state_q == ST_INS) ? sym_q : win_rdata_q;

	dtpm_step #(.NW(NW)) u_step (
		.row   (row),
		.sym   (step_sym),
		.nx    (nx),
		.flags (sflags)
	);

	logic [NW-1:0] new_idx;
	logic          room;
	logic [SW-1:0] wsum;
	logic [SW-1:0] wpos;
	logic [FW-1:0] fill_dec;

	assign new_idx  = node_count_q + NW'(1);
	assign room     = ((NW+1)'(node_count_q) + (NW+1)'(1)) < (NW+1)'(TRIE_NODES);
	assign wsum     = SW'(head_q) + SW'(fill_q);
	assign wpos     = (wsum >= SW'(MAX_PATTERN_LEN)) ? wsum - SW'(MAX_PATTERN_LEN) : wsum;
	assign fill_dec = fill_q - FW'(1);

	assign in_ready   = (state_q == ST_IDLE);
	assign table_full = overflow_q;

	always_comb begin
		state_d      = state_q;
		flush_d      = flush_q;
		end_d        = end_q;
		sym_d        = sym_q;
		node_count_d = node_count_q;
		ins_node_d   = ins_node_q;
		ins_depth_d  = ins_depth_q;
		ins_skip_d   = ins_skip_q;
		root_valid_d = root_valid_q;
		head_d       = head_q;
		fill_d       = fill_q;
		next_start_d = next_start_q;
		overflow_d   = overflow_q;
		walk_node_d  = walk_node_q;
		walk_k_d     = walk_k_q;
		rp_d         = rp_q;
		matched_d    = matched_q;
		new_node_d   = new_node_q;
		child_raddr  = ins_node_q;
		child_we     = 1'b0;
		child_waddr  = ins_node_q;
		child_wdata  = row;
		win_raddr    = head_q;
		win_we       = 1'b0;
		win_waddr    = wpos[WW-1:0];
		emit         = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					sym_d = in_item.sym;
					end_d = in_item.pend;
					unique case (in_item.cmd)
						CMD_PATTERN: begin
							if (!ins_skip_q && ins_depth_q < FW'(MAX_PATTERN_LEN)) begin
								child_raddr = ins_node_q;
								state_d     = ST_INS;
							end else if (in_item.pend) begin
								ins_node_d  = '0;
								ins_depth_d = '0;
								ins_skip_d  = 1'b0;
							end else begin
								ins_skip_d = 1'b1;
							end
						end
						CMD_TEXT: begin
							win_we  = 1'b1;
							fill_d  = fill_q + FW'(1);
							flush_d = 1'b0;
							if (fill_d >= FW'(MAX_PATTERN_LEN)) begin
								state_d = ST_START;
							end
						end
						CMD_FLUSH: begin
							flush_d = 1'b1;
							state_d = (fill_q == '0) ? ST_END : ST_START;
						end
						CMD_CLEAR: begin
							node_count_d = '0;
							ins_node_d   = '0;
							ins_depth_d  = '0;
							ins_skip_d   = 1'b0;
							root_valid_d = 1'b0;
							head_d       = '0;
							fill_d       = '0;
							next_start_d = '0;
							overflow_d   = 1'b0;
						end
						default: ;
					endcase
				end
			end
			ST_INS: begin
				state_d = ST_IDLE;
				if (!sflags.no_child) begin
					ins_node_d  = nx;
					ins_depth_d = ins_depth_q + FW'(1);
				end else if (room) begin
					for (int i = 0; i < 4; i++) begin
						if (sym_q == 2'(i)) begin
							child_wdata[i*NW +: NW] = new_idx;
						end
					end
					child_we     = 1'b1;
					child_waddr  = ins_node_q;
					node_count_d = new_idx;
					ins_node_d   = new_idx;
					ins_depth_d  = ins_depth_q + FW'(1);
					new_node_d   = new_idx;
					if (ins_node_q == '0) begin
						root_valid_d = 1'b1;
					end
					state_d = ST_INS_ZERO;
				end else begin
					overflow_d = 1'b1;
					ins_skip_d = 1'b1;
				end
				if (state_d == ST_IDLE && end_q) begin
					ins_node_d  = '0;
					ins_depth_d = '0;
					ins_skip_d  = 1'b0;
				end
			end
			ST_INS_ZERO: begin
				// A freshly allocated node starts with no children.
				child_we    = 1'b1;
				child_waddr = new_node_q;
				child_wdata = '0;
				state_d     = ST_IDLE;
				if (end_q) begin
					ins_node_d  = '0;
					ins_depth_d = '0;
					ins_skip_d  = 1'b0;
				end
			end
			ST_START: begin
				child_raddr = '0;
				win_raddr   = head_q;
				walk_node_d = '0;
				walk_k_d    = '0;
				rp_d        = head_q;
				state_d     = ST_EVAL;
			end
			ST_EVAL: begin
				priority if (sflags.leaf) begin
					matched_d = 1'b1;
					state_d   = ST_POST;
				end else if (walk_k_q >= fill_q || sflags.no_child) begin
					matched_d = 1'b0;
					state_d   = ST_POST;
				end else begin
					walk_node_d = nx;
					walk_k_d    = walk_k_q + FW'(1);
					rp_d        = wrap_inc(rp_q);
					child_raddr = nx;
					win_raddr   = rp_d;
				end
			end
			ST_POST: begin
				if (!matched_q || slot_free) begin
					emit.valid    = matched_q;
					emit.pos      = next_start_q;
					emit.is_match = 1'b1;
					emit.last     = !flush_q;
					head_d        = wrap_inc(head_q);
					fill_d        = fill_dec;
					next_start_d  = next_start_q + POS_W'(1);
					if (!flush_q) begin
						state_d = ST_IDLE;
					end else begin
						state_d = (fill_dec == '0) ? ST_END : ST_START;
					end
				end
			end
			ST_END: begin
				if (slot_free) begin
					emit.valid    = 1'b1;
					emit.pos      = '0;
					emit.is_match = 1'b0;
					emit.last     = 1'b1;
					head_d        = '0;
					next_start_d  = '0;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			flush_q      <= 1'b0;
			end_q        <= 1'b0;
			sym_q        <= '0;
			node_count_q <= '0;
			ins_node_q   <= '0;
			ins_depth_q  <= '0;
			ins_skip_q   <= 1'b0;
			root_valid_q <= 1'b0;
			head_q       <= '0;
			fill_q       <= '0;
			next_start_q <= '0;
			overflow_q   <= 1'b0;
			walk_node_q  <= '0;
			walk_k_q     <= '0;
			rp_q         <= '0;
			matched_q    <= 1'b0;
			new_node_q   <= '0;
		end else begin
			state_q      <= state_d;
			flush_q      <= flush_d;
			end_q        <= end_d;
			sym_q        <= sym_d;
			node_count_q <= node_count_d;
			ins_node_q   <= ins_node_d;
			ins_depth_q  <= ins_depth_d;
			ins_skip_q   <= ins_skip_d;
			root_valid_q <= root_valid_d;
			head_q       <= head_d;
			fill_q       <= fill_d;
			next_start_q <= next_start_d;
			overflow_q   <= overflow_d;
			walk_node_q  <= walk_node_d;
			walk_k_q     <= walk_k_d;
			rp_q         <= rp_d;
			matched_q    <= matched_d;
			new_node_q   <= new_node_d;
		end
	end

	a_emit_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> slot_free)
		else $error("result issued while the output slot is occupied");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MAX_PATTERN_LEN))
		else $error("text window fill exceeds its depth");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> (walk_k_q <= fill_q))
		else $error("trie walk ran past the window contents");

	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && !emit.is_match) |-> (emit.last && emit.pos == '0))
		else $error("end-of-text marker malformed");

	a_node_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(NW+1)'(node_count_q) < (NW+1)'(TRIE_NODES))
		else $error("node count beyond the node store");

endmodule

`default_nettype wire

// ----- sv/dna_trie_multi_pattern_matcher.sv -----
// A pattern symbol reads its child-table row, then descends or adds a node and zeroes
// the new row; a text symbol that fills the window starts the trie walk, one row read
// per cycle. The core takes one item at a time; end of text walks the trie from each
// window position in turn, then sends the end marker, and waits while output stalls.
// Reset: asynchronous, active low; control state clears at once, no memory clearing pass.
// Top level of the DNA trie pattern matcher: stream ports and output register.
`default_nettype none

module dna_trie_multi_pattern_matcher import dtpm_pkg::*; #(
	parameter int TRIE_NODES      = 1024,
	parameter int MAX_PATTERN_LEN = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [1:0] symbol
	input  wire logic [1:0] s_tuser,   // [1:0] command
	input  wire logic       s_tlast,   // pattern_end
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [23:0]     m_tdata,   // [19:0] match_position, [20] table_full
	output logic            m_tuser,   // is_match
	output logic            m_tlast    // last
);

	dtpm_item_t       item;
	dtpm_emit_t       emit;
	logic             slot_free;
	logic             table_full;

	logic             m_tvalid_q;
	logic [POS_W-1:0] m_pos_q;
	logic             m_is_match_q;
	logic             m_last_q;
	logic             m_full_q;

	assign item.cmd  = s_tuser;
	assign item.sym  = s_tdata[1:0];
	assign item.pend = s_tlast;

	// The output slot can take a new result in the same cycle the old one is taken.
	assign slot_free = !m_tvalid_q || m_tready;

	dtpm_core #(
		.TRIE_NODES      (TRIE_NODES),
		.MAX_PATTERN_LEN (MAX_PATTERN_LEN)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (item),
		.slot_free  (slot_free),
		.emit       (emit),
		.table_full (table_full)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			m_pos_q      <= emit.pos;
			m_is_match_q <= emit.is_match;
			m_last_q     <= emit.last;
			m_full_q     <= table_full;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, m_full_q, m_pos_q};
	assign m_tuser  = m_is_match_q;
	assign m_tlast  = m_last_q;

endmodule

`default_nettype wire
